// File: sv/rle_lit_pkg.sv
// Shared types, constants and helpers of the run-length encoder with literal groups.
package rle_lit_pkg;

	localparam int BYTE_W        = 8;
	localparam int CNT_W         = 4;
	localparam int RLE_MAX_GROUP = 9;

	localparam logic [BYTE_W-1:0] CODE_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] CODE_ONE  = 8'h31;
	localparam logic [BYTE_W-1:0] CODE_DASH = 8'h2D;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		JOB_NONE,
		JOB_RUN,
		JOB_LIT
	} job_kind_t;

	// One pending group of output bytes
	typedef struct packed {
		job_kind_t           kind;
		logic [CNT_W-1:0]    cnt;
		logic [BYTE_W-1:0]   data;
	} job_t;

	// Controller to datapath
	typedef struct packed {
		logic             load;
		logic             emit;
		logic             sel;
		logic [CNT_W-1:0] idx;
		logic             last;
	} rle_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic             has_job0;
		logic             has_job1;
		logic [CNT_W-1:0] len0;
		logic [CNT_W-1:0] len1;
		logic             out_free;
	} rle_sts_t;

	// Number of bytes a group produces
	function automatic logic [CNT_W-1:0] job_len(input job_t job);
		logic [CNT_W-1:0] len;
		len = '0;
		case (job.kind)
			JOB_RUN: len = CNT_W'(2);
			JOB_LIT: len = (job.cnt == CNT_W'(1)) ? CNT_W'(2) : job.cnt + CNT_W'(2);
			default: len = '0;
		endcase
		return len;
	endfunction

endpackage

// File: sv/rle_lit_ctrl.sv
// Controller: accepts items and walks the pending groups byte by byte.
module rle_lit_ctrl
	import rle_lit_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rle_sts_t sts,
	output rle_cmd_t cmd
);

	state_t           state_q, state_d;
	logic             sel_q, sel_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] cur_len;
	logic             job_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			idx_q   <= idx_d;
		end
	end

	assign cur_len = sel_q ? sts.len1 : sts.len0;
	assign job_end = (idx_q == cur_len - CNT_W'(1));

	always_comb begin
		state_d  = state_q;
		sel_d    = sel_q;
		idx_d    = idx_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.sel  = sel_q;
		cmd.idx  = idx_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EMIT;
					sel_d    = 1'b0;
					idx_d    = '0;
				end
			end
			ST_EMIT: begin
				if (!sts.has_job0) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (job_end) begin
						cmd.last = sel_q || !sts.has_job1;
						if (!sel_q && sts.has_job1) begin
							sel_d = 1'b1;
							idx_d = '0;
						end else begin
							state_d = ST_IDLE;
						end
					end else begin
						idx_d = idx_q + CNT_W'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: sv/rle_lit_dp.sv
// Datapath: run and literal state, literal store, pending groups and output register.
module rle_lit_dp
	import rle_lit_pkg::*;
#(
	parameter int MAX_GROUP = RLE_MAX_GROUP
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              end_of_stream,
	input  rle_cmd_t          cmd,
	output rle_sts_t          sts,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [BYTE_W-1:0] code_byte,
	output logic              last_of_run
);

	localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_GROUP);

	logic [BYTE_W-1:0] prev_q;
	logic [CNT_W-1:0]  run_q, lc_q;
	logic [BYTE_W-1:0] store_q [MAX_GROUP];
	job_t              job0_q, job1_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] code_q;
	logic              last_q;

	logic [CNT_W-1:0]  run_d, lc_d, lc_inc;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	job_t              main_job, flush_job;
	job_t              cur_job;
	logic [CNT_W-1:0]  idx_m2;
	logic [BYTE_W-1:0] byte_sel;

	// Next state of the encoder for the offered byte
	always_comb begin
		run_d     = run_q;
		lc_d      = lc_q;
		wr_en     = 1'b0;
		wr_addr   = '0;
		main_job  = '{kind: JOB_NONE, cnt: '0, data: '0};
		flush_job = '{kind: JOB_NONE, cnt: '0, data: '0};
		lc_inc    = lc_q + CNT_W'(1);
		if (run_q != '0) begin
			if (data_byte == prev_q) begin
				if (run_q >= MAX_CNT) begin
					main_job = '{kind: JOB_RUN, cnt: run_q, data: prev_q};
					run_d    = CNT_W'(1);
				end else begin
					run_d = run_q + CNT_W'(1);
				end
			end else begin
				main_job = '{kind: JOB_RUN, cnt: run_q, data: prev_q};
				run_d    = '0;
				wr_en    = 1'b1;
				lc_d     = CNT_W'(1);
			end
		end else if (lc_q != '0) begin
			if (data_byte == prev_q) begin
				if (lc_q >= CNT_W'(2))
					main_job = '{kind: JOB_LIT, cnt: lc_q - CNT_W'(1), data: '0};
				lc_d  = '0;
				run_d = CNT_W'(2);
			end else begin
				if (lc_q < MAX_CNT) begin
					wr_en   = 1'b1;
					wr_addr = lc_q[IDX_W-1:0];
				end
				lc_d = lc_inc;
				if (lc_inc >= MAX_CNT) begin
					main_job = '{kind: JOB_LIT, cnt: MAX_CNT, data: '0};
					lc_d     = '0;
				end
			end
		end else begin
			wr_en = 1'b1;
			lc_d  = CNT_W'(1);
		end
		if (end_of_stream) begin
			if (run_d != '0)
				flush_job = '{kind: JOB_RUN, cnt: run_d, data: data_byte};
			else if (lc_d != '0)
				flush_job = '{kind: JOB_LIT, cnt: lc_d, data: '0};
			run_d = '0;
			lc_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			run_q       <= '0;
			lc_q        <= '0;
			job0_q      <= '{kind: JOB_NONE, cnt: '0, data: '0};
			job1_q      <= '{kind: JOB_NONE, cnt: '0, data: '0};
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				prev_q <= data_byte;
				run_q  <= run_d;
				lc_q   <= lc_d;
				// Keep the first pending group in slot zero
				if (main_job.kind != JOB_NONE) begin
					job0_q <= main_job;
					job1_q <= flush_job;
				end else begin
					job0_q <= flush_job;
					job1_q <= '{kind: JOB_NONE, cnt: '0, data: '0};
				end
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && wr_en)
			store_q[wr_addr] <= data_byte;
	end

	// Byte of the current group at the current position
	assign cur_job = cmd.sel ? job1_q : job0_q;
	assign idx_m2  = cmd.idx - CNT_W'(2);

	always_comb begin
		byte_sel = '0;
		case (cur_job.kind)
			JOB_RUN: begin
				byte_sel = (cmd.idx == '0) ? CODE_ZERO + BYTE_W'(cur_job.cnt) : cur_job.data;
			end
			JOB_LIT: begin
				if (cur_job.cnt == CNT_W'(1))
					byte_sel = (cmd.idx == '0) ? CODE_ONE : store_q[0];
				else if (cmd.idx == '0)
					byte_sel = CODE_DASH;
				else if (cmd.idx == CNT_W'(1))
					byte_sel = CODE_ZERO + BYTE_W'(cur_job.cnt);
				else
					byte_sel = store_q[idx_m2[IDX_W-1:0]];
			end
			default: byte_sel = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			code_q <= byte_sel;
			last_q <= cmd.last;
		end
	end

	assign sts.has_job0 = (job0_q.kind != JOB_NONE);
	assign sts.has_job1 = (job1_q.kind != JOB_NONE);
	assign sts.len0     = job_len(job0_q);
	assign sts.len1     = job_len(job1_q);
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign code_byte   = code_q;
	assign last_of_run = last_q;

endmodule

// File: sv/rle_encoder_literal_runs.sv
// Top level of the run-length encoder with literal groups.
//
// Input channel: one raw byte per item (data_byte) with end_of_stream on the
// final byte of a stream, handshaked by in_valid / in_ready.
// Output channel: one encoded byte per item (code_byte); last_of_run is set on
// the final byte caused by an input item. Handshake is out_valid / out_ready.
// Runs are coded as an ASCII digit and the byte, literal groups as '-', a
// digit and the bytes, a lone literal as '1' and the byte; end_of_stream
// flushes whatever is pending and starts the next stream afresh.
// The first byte of an item is registered in the pending group slots and then
// in the output register before it shows. The block takes no new item until it
// is through with the last one: an item produces n bytes (0 to 11), and the
// controller hands out one byte per cycle, while the receiver does not stall,
// through a single output register.
// Reset clears all run and literal state; the literal store is not cleared
// and needs no clearing pass. When the receiver stalls, the output register
// holds its byte and the controller waits; the input stays blocked until the
// last byte of the current item has been loaded into the output register.
module rle_encoder_literal_runs
	import rle_lit_pkg::*;
#(
	parameter int MAX_GROUP = RLE_MAX_GROUP
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              end_of_stream,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] code_byte,
	output logic              last_of_run
);

	rle_cmd_t cmd;
	rle_sts_t sts;

	// Sequencer: takes an item, then steps through the pending groups
	rle_lit_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Encoder state, literal store and output register
	rle_lit_dp #(
		.MAX_GROUP (MAX_GROUP)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.cmd           (cmd),
		.sts           (sts),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.code_byte     (code_byte),
		.last_of_run   (last_of_run)
	);

`ifndef ASSERT_OFF
	// After an item is taken, the input is closed in the next cycle for group processing
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken right after an accepted item");

	// Bytes are only produced while a group is pending
	a_emit_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.has_job0)
		else $error("byte emitted with no pending group");

	// The second group slot is only walked when it is filled
	a_second_job: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && cmd.sel |-> sts.has_job1)
		else $error("byte emitted from an empty second group");

	// No new item while bytes are being emitted
	a_emit_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !in_ready)
		else $error("input open while emitting");
`endif

endmodule

// File: test/rle_encoder_literal_runs_tb.sv
// Self-checking testbench for the run-length encoder with literal groups.
module rle_encoder_literal_runs_tb
	import rle_lit_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          GROUP_MAX    = RLE_MAX_GROUP;
	localparam int          RANDOM_ITEMS = 90;
	localparam int          DRAIN_CYCLES = 32;
	localparam int          HOLD_CYCLES  = 120;
	localparam int          HOLD_AFTER   = 40;
	// Slowest run: ~170 items, each up to 11 bytes with a long receiver stall on each, plus gaps.
	localparam int unsigned CYCLE_LIMIT  = 200000;

	// One raw input byte with its end-of-stream marker
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              eos;
	} raw_item_t;

	// One encoded output byte with its end-of-item marker
	typedef struct packed {
		logic [BYTE_W-1:0] code;
		logic              last;
	} code_item_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              in_valid      = 1'b0;
	logic              in_ready;
	logic [BYTE_W-1:0] data_byte     = '0;
	logic              end_of_stream = 1'b0;
	logic              out_valid;
	logic              out_ready     = 1'b0;
	logic [BYTE_W-1:0] code_byte;
	logic              last_of_run;

	raw_item_t   raw_q[$];      // input bytes still to be offered
	code_item_t  enc_bytes_q[$]; // encoded bytes predicted but not yet seen

	// Encoder state mirrored by the predictor
	logic [BYTE_W-1:0] prev_byte = '0;
	logic [CNT_W-1:0]  run_n     = '0;
	logic [CNT_W-1:0]  lit_n     = '0;
	logic [BYTE_W-1:0] lit_mem [GROUP_MAX];

	int unsigned errors      = 0;
	int unsigned items_taken = 0;
	int unsigned codes_seen  = 0;
	int unsigned streams     = 0;
	int unsigned cycle_count = 0;
	int unsigned hold_left   = 0;
	bit          hold_done   = 1'b0;
	int unsigned in_gap      = 0;
	int unsigned out_stall   = 0;
	bit          in_burst    = 1'b0;
	bit          out_burst   = 1'b0;

	rle_encoder_literal_runs u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.code_byte     (code_byte),
		.last_of_run   (last_of_run)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor: encode one accepted byte, queue the bytes it releases
	// ------------------------------------------------------------------
	task automatic put_code(input logic [BYTE_W-1:0] v);
		code_item_t c;
		c.code = v;
		c.last = 1'b0;
		enc_bytes_q.insert(enc_bytes_q.size(), c);
	endtask

	// Pending run: digit count, then the repeated byte
	task automatic put_run();
		put_code(CODE_ZERO + BYTE_W'(run_n));
		put_code(prev_byte);
	endtask

	// Pending literals: lone byte as '1' and the byte, else '-', count, bytes
	task automatic put_literals(input int unsigned n);
		if (n > GROUP_MAX) n = GROUP_MAX;
		if (n == 1) begin
			put_code(CODE_ONE);
			put_code(lit_mem[0]);
		end else if (n > 1) begin
			put_code(CODE_DASH);
			put_code(CODE_ZERO + BYTE_W'(n));
			for (int i = 0; i < n; i++)
				put_code(lit_mem[CNT_W'(i)]);
		end
	endtask

	task automatic encode_item(input logic [BYTE_W-1:0] b, input logic eos);
		int unsigned base;
		base = enc_bytes_q.size();
		if (run_n != 0) begin
			if (b == prev_byte) begin
				// a full chunk goes out, the run carries on with this byte
				if (run_n >= GROUP_MAX) begin
					put_run();
					run_n = CNT_W'(1);
				end else begin
					run_n = run_n + 1'b1;
				end
			end else begin
				put_run();
				run_n      = '0;
				lit_mem[0] = b;
				lit_n      = CNT_W'(1);
			end
		end else if (lit_n != 0) begin
			if (b == prev_byte) begin
				// the last literal becomes the head of a run of two
				if (lit_n >= 2) put_literals(lit_n - 1);
				lit_n = '0;
				run_n = CNT_W'(2);
			end else begin
				if (lit_n < GROUP_MAX) lit_mem[lit_n] = b;
				lit_n = lit_n + 1'b1;
				// a full literal group is flushed at once, nothing stays pending
				if (lit_n >= GROUP_MAX) begin
					put_literals(lit_n);
					lit_n = '0;
				end
			end
		end else begin
			lit_mem[0] = b;
			lit_n      = CNT_W'(1);
		end
		prev_byte = b;
		if (eos) begin
			if (run_n != 0) put_run();
			else if (lit_n != 0) put_literals(lit_n);
			run_n = '0;
			lit_n = '0;
		end
		if (enc_bytes_q.size() > base)
			enc_bytes_q[enc_bytes_q.size() - 1].last = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic void add_item(input logic [BYTE_W-1:0] b, input logic eos);
		raw_item_t r;
		r.data = b;
		r.eos  = eos;
		raw_q.insert(raw_q.size(), r);
	endfunction

	// Mostly no gap, often a short one, now and then a long one
	function automatic int unsigned pick_gap(input bit burst);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (burst || r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// One stream of well-formed runs and literal groups, with some noise,
	// closed by an end-of-stream byte; returns the item count
	function automatic int unsigned add_stream(input int unsigned budget);
		int unsigned n;
		int unsigned len;
		int unsigned kind;
		logic [BYTE_W-1:0] b;
		logic [BYTE_W-1:0] last_b;
		n      = 0;
		last_b = BYTE_W'($urandom_range(0, 255));
		while (n < budget) begin
			kind = $urandom_range(0, 9);
			if (kind < 4) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20)
				                                  : $urandom_range(2, 8);
				b   = BYTE_W'($urandom_range(0, 255));
				for (int k = 0; k < len; k++) add_item(b, 1'b0);
			end else if (kind < 8) begin
				len = $urandom_range(1, 11);
				for (int k = 0; k < len; k++) begin
					b = BYTE_W'($urandom_range(0, 255));
					if (b == last_b) b = ~b;
					add_item(b, 1'b0);
					last_b = b;
				end
			end else begin
				// noise over a tiny alphabet: random runs and pairs
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++) begin
					b = 8'h61 + BYTE_W'($urandom_range(0, 2));
					add_item(b, 1'b0);
				end
			end
			last_b = b;
			n += len;
		end
		raw_q[raw_q.size() - 1].eos = 1'b1;
		return n;
	endfunction

	task automatic note_mismatch(input string field, input int unsigned got,
	                             input int unsigned want);
		$display("mismatch on encoded byte %0d: %s got 0x%02h, want 0x%02h",
		         codes_seen, field, got, want);
		errors++;
	endtask

	// ------------------------------------------------------------------
	// Driver: offer queued bytes, predict on each accepted item
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive_proc
		logic offer;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			offer = in_valid;
			if (in_valid && in_ready) begin
				encode_item(data_byte, end_of_stream);
				void'(raw_q.pop_front());
				items_taken <= items_taken + 1;
				offer = 1'b0;
				if ($urandom_range(0, 15) == 0) in_burst = ~in_burst;
				in_gap = pick_gap(in_burst);
			end
			if (!offer) begin
				// keep offering during the receiver hold-off so the block backs up
				if (in_gap > 0 && hold_left == 0) begin
					in_gap--;
				end else if (raw_q.size() != 0) begin
					offer         = 1'b1;
					data_byte     <= raw_q[0].data;
					end_of_stream <= raw_q[0].eos;
				end
			end
			in_valid <= offer;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check each accepted encoded byte, stall at random
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch_proc
		code_item_t want;
		logic       rdy;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				codes_seen <= codes_seen + 1;
				if (enc_bytes_q.size() == 0) begin
					note_mismatch("unexpected code_byte", code_byte, 0);
				end else begin
					want = enc_bytes_q.pop_front();
					if (code_byte !== want.code)
						note_mismatch("code_byte", code_byte, want.code);
					if (last_of_run !== want.last)
						note_mismatch("last_of_run", last_of_run, want.last);
				end
				if ($urandom_range(0, 15) == 0) out_burst = ~out_burst;
				out_stall = pick_gap(out_burst);
			end
			if (hold_left != 0) begin
				rdy = 1'b0;
			end else if (out_stall != 0) begin
				out_stall--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			out_ready <= rdy;
		end
	end

	// Hold the receiver off once for a long stretch, mid-run
	always @(posedge clk) begin : hold_proc
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && codes_seen >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Watchdog
	always @(posedge clk) begin : watchdog_proc
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d encoded bytes outstanding",
			         cycle_count, enc_bytes_q.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin : main_proc
		int unsigned rand_items;

		// lone byte closing its stream
		add_item(8'h00, 1'b1);
		// run past the chunk size, remainder broken by a literal, which a
		// run of two then breaks in turn
		for (int k = 0; k < 10; k++) add_item(8'hFF, 1'b0);
		add_item(8'h41, 1'b0);
		add_item(8'h42, 1'b0);
		add_item(8'h42, 1'b0);
		add_item(8'h80, 1'b1);
		// full literal group, then a repeat of its last byte starts afresh
		for (int k = 1; k <= GROUP_MAX; k++) add_item(BYTE_W'(k), 1'b0);
		add_item(8'h09, 1'b0);
		add_item(8'h09, 1'b1);
		streams = 3;

		rand_items = 0;
		while (rand_items < RANDOM_ITEMS) begin
			rand_items += add_stream(($urandom_range(0, 5) == 0) ? 1
			                                                     : $urandom_range(4, 30));
			streams++;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (raw_q.size() != 0 || enc_bytes_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d streams, %0d input items, %0d encoded bytes checked",
		         streams, items_taken, codes_seen);
		$display("receiver held off %0d cycles once mid-run; %0d mismatches",
		         HOLD_CYCLES, errors);
		if (errors == 0 && enc_bytes_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
